// ===== rtl/akt_pkg.sv =====
// Package for the address key table: field widths, command and status codes, sequencer states.
`default_nettype none
package akt_pkg;
	localparam int ADDR_BITS = 48;
	localparam int KIND_BITS = 8;
	localparam int KEY_BITS  = ADDR_BITS + KIND_BITS;
	localparam int CFG_BITS  = 5;
	localparam int SLOT_BITS = 4;
	localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

	typedef enum logic [1:0] {
		CMD_FIND = 2'd0,
		CMD_ADD  = 2'd1,
		CMD_DEL  = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_REJECTED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} seq_state_t;
endpackage
`default_nettype wire

// ===== rtl/akt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module akt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/address_key_table_core.sv =====
// Address key table core: associative key table scanned through one RAM.
//
// Usage: an item (cmd, device_address, address_kind, key_data,
// identity_key_ok) is accepted on a rising edge with start high and busy
// low. busy stays high while the table is scanned. The result (status,
// found_data, slot_index) is shown for one cycle with done high; the
// receiver cannot stall, so it must take it in that cycle.
// After the accept, busy stays high through a scan of n slots, where n is
// entries_in_use limited to TABLE_DEPTH: one RAM read per slot through the
// single read port, a registered read, a wait until the read pipe is seen
// empty, then the write-back; done follows in the next cycle. A new item
// is accepted in the cycle that done is shown.
// The entries_in_use register is written with cfg_wdata when cfg_we is high,
// and is to be written only while idle.
// Reset clears all valid bits and all written marks, so every key reads as
// zero and entries_in_use returns to 16; no clearing pass is needed. Key
// data is undefined until an add writes the slot.
`default_nettype none
module address_key_table_core
	import akt_pkg::*;
#(
	parameter int TABLE_DEPTH = 16,
	parameter int DATA_BITS   = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_BITS-1:0]  cfg_wdata,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [1:0]           cmd,
	input  wire logic [ADDR_BITS-1:0] device_address,
	input  wire logic [KIND_BITS-1:0] address_kind,
	input  wire logic [DATA_BITS-1:0] key_data,
	input  wire logic                 identity_key_ok,
	output logic                      done,
	output logic [1:0]                status,
	output logic [DATA_BITS-1:0]      found_data,
	output logic [SLOT_BITS-1:0]      slot_index
);
	localparam int IW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = IW + 1;
	localparam int RW = KEY_BITS + DATA_BITS;

	seq_state_t state_q;
	logic [CFG_BITS-1:0] cfg_q;
	logic [CW-1:0] cnt_q;
	logic [8:0] n_wide;
	logic [CW-1:0] n_used;

	cmd_t cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [DATA_BITS-1:0] data_q;
	logic id_ok_q;

	logic [TABLE_DEPTH-1:0] vld_q;
	logic [TABLE_DEPTH-1:0] wr_q;

	logic rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	logic [RW-1:0] ram_rdata;
	logic ram_we;
	logic [IW-1:0] ram_waddr;

	logic hit_q, match_q, free_q;
	logic [IW-1:0] hit_idx_q, match_idx_q, free_idx_q;
	logic [DATA_BITS-1:0] hit_data_q;

	logic [KEY_BITS-1:0] rd_key;
	logic rd_eq, rd_valid;
	logic accept, issue;
	logic [IW-1:0] pick_idx;
	logic [IW+SLOT_BITS-1:0] pick_ext, hit_ext;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	assign n_wide = ({4'b0, cfg_q} > 9'(TABLE_DEPTH)) ? 9'(TABLE_DEPTH) : {4'b0, cfg_q};
	assign n_used = n_wide[CW-1:0];
	assign issue  = (state_q == S_SCAN) && (cnt_q < n_used);

	// never-written slots read as a zero key
	assign rd_key   = wr_q[rd_idx_s1] ? ram_rdata[RW-1:DATA_BITS] : '0;
	assign rd_eq    = (rd_key == key_q);
	assign rd_valid = vld_q[rd_idx_s1];

	assign pick_idx = match_q ? match_idx_q : free_idx_q;
	assign ram_we   = (state_q == S_FINISH) && (cmd_q == CMD_ADD) && (match_q || free_q);
	assign ram_waddr = pick_idx;
	assign pick_ext = {{SLOT_BITS{1'b0}}, pick_idx};
	assign hit_ext  = {{SLOT_BITS{1'b0}}, hit_idx_q};

	akt_ram #(
		.WIDTH(RW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata({key_q, data_q}),
		.raddr(cnt_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			done      <= 1'b0;
		end else begin
			done      <= 1'b0;
			rd_vld_s1 <= issue;
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!rd_vld_s1) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[IW-1:0];
		if (accept) begin
			cmd_q   <= cmd_t'(cmd);
			key_q   <= {address_kind, device_address};
			data_q  <= key_data;
			id_ok_q <= identity_key_ok;
		end
	end

	// scan results: first valid hit, last key match, first free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (accept) begin
			hit_q   <= 1'b0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (rd_vld_s1) begin
			if (rd_valid && rd_eq && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (rd_eq) begin
				match_q <= 1'b1;
			end
			if (!rd_valid && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (rd_valid && rd_eq && !hit_q) begin
				hit_idx_q  <= rd_idx_s1;
				hit_data_q <= ram_rdata[DATA_BITS-1:0];
			end
			if (rd_eq) begin
				match_idx_q <= rd_idx_s1;
			end
			if (!rd_valid && !free_q) begin
				free_idx_q <= rd_idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			wr_q  <= '0;
		end else begin
			if (rd_vld_s1 && (cmd_q == CMD_DEL) && rd_valid && rd_eq) begin
				vld_q[rd_idx_s1] <= 1'b0;
			end
			if (ram_we) begin
				vld_q[pick_idx] <= id_ok_q;
				wr_q[pick_idx]  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH) begin
			status     <= ST_NOTFOUND;
			found_data <= '0;
			slot_index <= '0;
			case (cmd_q)
				CMD_FIND: begin
					if (hit_q) begin
						status     <= ST_OK;
						found_data <= hit_data_q;
						slot_index <= hit_ext[SLOT_BITS-1:0];
					end
				end
				CMD_ADD: begin
					if (match_q || free_q) begin
						status     <= id_ok_q ? ST_OK : ST_REJECTED;
						slot_index <= pick_ext[SLOT_BITS-1:0];
					end else begin
						status <= ST_FULL;
					end
				end
				CMD_DEL: status <= ST_OK;
				default: status <= ST_NOTFOUND;
			endcase
		end
	end

	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_FINISH))
		else $error("result strobe without a finishing item");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted item did not start a scan");

	a_write_on_add: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_FINISH && cmd_q == CMD_ADD))
		else $error("table written outside an add");

	a_no_read_in_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) |-> (!rd_vld_s1 && !issue))
		else $error("scan still active at write-back");
endmodule
`default_nettype wire

// ===== dv/akt_table_checker.sv =====
// Checker for the address key table core: tracks the table, predicts each reply and compares.
`timescale 1ns / 1ps
module akt_table_checker
	import akt_pkg::*;
#(
	parameter int TABLE_DEPTH = 16,
	parameter int DATA_BITS   = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_BITS-1:0]  cfg_wdata,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire logic [1:0]           cmd,
	input  wire logic [ADDR_BITS-1:0] device_address,
	input  wire logic [KIND_BITS-1:0] address_kind,
	input  wire logic [DATA_BITS-1:0] key_data,
	input  wire logic                 identity_key_ok,
	input  wire logic                 done,
	input  wire logic [1:0]           status,
	input  wire logic [DATA_BITS-1:0] found_data,
	input  wire logic [SLOT_BITS-1:0] slot_index,
	output int                        errors,
	output int                        outstanding
);
	typedef struct {
		status_t                status;
		logic [DATA_BITS-1:0]   data;
		logic [SLOT_BITS-1:0]   slot;
	} reply_t;

	logic                 slot_valid [TABLE_DEPTH];
	logic [KEY_BITS-1:0]  slot_key   [TABLE_DEPTH];
	logic [DATA_BITS-1:0] slot_data  [TABLE_DEPTH];
	logic [CFG_BITS-1:0]  span_cfg;
	reply_t               reply_q [$];
	int                   err_count;

	// applies one table operation to the shadow table and returns its reply
	function automatic reply_t apply_table_op(cmd_t op, logic [KEY_BITS-1:0] key,
			logic [DATA_BITS-1:0] d, logic ok);
		reply_t r;
		int n;
		int i;
		int hit_idx;
		int free_idx;
		bit have_hit;
		bit have_free;
		r.status = ST_NOTFOUND;
		r.data   = '0;
		r.slot   = '0;
		n = (span_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(span_cfg);
		have_hit  = 0;
		have_free = 0;
		hit_idx   = 0;
		free_idx  = 0;
		case (op)
			CMD_FIND: begin
				for (i = 0; i < n; i++) begin
					if (!have_hit && slot_valid[i] && slot_key[i] == key) begin
						have_hit = 1;
						r.status = ST_OK;
						r.data   = slot_data[i];
						r.slot   = SLOT_BITS'(i);
					end
				end
			end
			CMD_ADD: begin
				// last key match wins, valid or not; otherwise first free slot
				for (i = 0; i < n; i++) begin
					if (slot_key[i] == key) begin
						have_hit = 1;
						hit_idx  = i;
					end
					if (!slot_valid[i] && !have_free) begin
						have_free = 1;
						free_idx  = i;
					end
				end
				if (!have_hit && !have_free) begin
					r.status = ST_FULL;
				end else begin
					if (!have_hit)
						hit_idx = free_idx;
					slot_key[hit_idx]   = key;
					slot_data[hit_idx]  = d;
					slot_valid[hit_idx] = ok;
					r.status = ok ? ST_OK : ST_REJECTED;
					r.slot   = SLOT_BITS'(hit_idx);
				end
			end
			CMD_DEL: begin
				for (i = 0; i < n; i++) begin
					if (slot_valid[i] && slot_key[i] == key)
						slot_valid[i] = 0;
				end
				r.status = ST_OK;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				slot_valid[i] = 0;
				slot_key[i]   = '0;
				slot_data[i]  = '0;
			end
			span_cfg = CFG_RESET;
			reply_q.delete();
			err_count = 0;
			errors      <= 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (reply_q.size() == 0) begin
					err_count++;
					$display("%t: reply with no item outstanding: status %0d data %h slot %0d",
						$time, status, found_data, slot_index);
				end else begin
					want = reply_q.pop_front();
					if (status !== want.status || found_data !== want.data
							|| slot_index !== want.slot) begin
						err_count++;
						$display({"%t: mismatch: expected status %0d data %h slot %0d,",
							" got status %0d data %h slot %0d"}, $time, want.status,
							want.data, want.slot, status, found_data, slot_index);
					end
				end
			end
			if (cfg_we)
				span_cfg = cfg_wdata;
			if (start && !busy)
				reply_q.push_back(apply_table_op(cmd_t'(cmd), {address_kind, device_address},
					key_data, identity_key_ok));
			errors      <= err_count;
			outstanding <= reply_q.size();
		end
	end
endmodule

// ===== dv/tb_address_key_table_core.sv =====
// Testbench top for the address key table core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_address_key_table_core
	import akt_pkg::*;
();

	localparam int TABLE_DEPTH = 16;
	localparam int DATA_BITS   = 64;
	localparam logic [ADDR_BITS-1:0] ALT_ADDR = 48'h0123_4567_89ab;
	localparam logic [KIND_BITS-1:0] ALT_KIND = 8'h5a;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_BITS-1:0]  cfg_wdata = '0;
	logic                 start = 1'b0;
	logic [1:0]           cmd = CMD_FIND;
	logic [ADDR_BITS-1:0] device_address = '0;
	logic [KIND_BITS-1:0] address_kind = '0;
	logic [DATA_BITS-1:0] key_data = '0;
	logic                 identity_key_ok = 1'b0;
	logic                 busy;
	logic                 done;
	logic [1:0]           status;
	logic [DATA_BITS-1:0] found_data;
	logic [SLOT_BITS-1:0] slot_index;
	int                   fail_count;
	int                   results_owed;
	bit                   burst = 0;

	always #5 clk = ~clk;

	address_key_table_core #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.DATA_BITS(DATA_BITS)
	) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .cmd(cmd), .device_address(device_address),
		.address_kind(address_kind), .key_data(key_data),
		.identity_key_ok(identity_key_ok), .done(done), .status(status),
		.found_data(found_data), .slot_index(slot_index)
	);

	akt_table_checker #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.DATA_BITS(DATA_BITS)
	) u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .cmd(cmd), .device_address(device_address),
		.address_kind(address_kind), .key_data(key_data),
		.identity_key_ok(identity_key_ok), .done(done), .status(status),
		.found_data(found_data), .slot_index(slot_index),
		.errors(fail_count), .outstanding(results_owed)
	);

	// presents one item and returns at the edge it is taken; start stays up
	task automatic send(input cmd_t op, input logic [ADDR_BITS-1:0] a,
			input logic [KIND_BITS-1:0] k, input logic [DATA_BITS-1:0] d, input logic ok);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start           <= 1'b1;
		cmd             <= op;
		device_address  <= a;
		address_kind    <= k;
		key_data        <= d;
		identity_key_ok <= ok;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
	endtask

	task automatic set_span(input logic [CFG_BITS-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic [ADDR_BITS-1:0] pool_addr [32];
		logic [KIND_BITS-1:0] pool_kind [32];
		logic [CFG_BITS-1:0]  span_plan [8];
		logic [ADDR_BITS-1:0] a;
		logic [KIND_BITS-1:0] k;
		cmd_t op;
		int pool_n;
		int roll;
		int pi;

		span_plan = '{5'd16, 5'd31, 5'd4, 5'd1, 5'd17, 5'd0, 5'd2, 5'd16};
		for (int i = 0; i < 32; i++) begin
			pool_addr[i] = ADDR_BITS'({$urandom, $urandom});
			pool_kind[i] = KIND_BITS'($urandom);
		end
		pool_addr[0] = '0;  pool_kind[0] = '0;
		pool_addr[1] = '1;  pool_kind[1] = '1;
		pool_addr[2] = '0;  pool_kind[2] = '1;
		pool_addr[3] = '1;  pool_kind[3] = '0;
		// same address, different type byte
		pool_addr[5] = pool_addr[4];
		pool_kind[5] = pool_kind[4] ^ 8'h01;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stale zero keys, rejected add, type byte in key, unused command
		send(CMD_FIND, '0, '0, '0, 1'b1);
		send(CMD_ADD, '0, '0, '1, 1'b1);
		send(CMD_FIND, '0, '0, '0, 1'b0);
		send(CMD_ADD, '1, '1, '0, 1'b1);
		send(CMD_FIND, '1, '1, '1, 1'b0);
		send(CMD_ADD, ALT_ADDR, ALT_KIND, 64'h0f1e_2d3c_4b5a_6978, 1'b0);
		send(CMD_FIND, ALT_ADDR, ALT_KIND, '0, 1'b0);
		send(CMD_ADD, ALT_ADDR, ALT_KIND, 64'h8796_a5b4_c3d2_e1f0, 1'b1);
		send(CMD_FIND, ALT_ADDR, ALT_KIND ^ 8'h80, '0, 1'b1);
		send(CMD_DEL, ALT_ADDR, ALT_KIND, '1, 1'b1);
		send(CMD_FIND, ALT_ADDR, ALT_KIND, '0, 1'b1);
		send(CMD_NONE, '1, '1, '1, 1'b1);
		send(CMD_DEL, '0, '0, '0, 1'b0);
		// no slots searched
		set_span(5'd0);
		send(CMD_FIND, '1, '1, '0, 1'b1);
		send(CMD_ADD, '1, '1, '1, 1'b1);
		send(CMD_DEL, '1, '1, '0, 1'b1);
		// one slot, already taken: add of a new key finds no room
		set_span(5'd1);
		send(CMD_ADD, ALT_ADDR, ALT_KIND, '1, 1'b1);
		send(CMD_FIND, '1, '1, '0, 1'b0);
		// register above depth saturates
		set_span(5'd31);
		send(CMD_FIND, '0, '0, '0, 1'b1);
		send(CMD_ADD, '0, '0, 64'h5555_aaaa_5555_aaaa, 1'b1);
		set_span(5'd2);
		send(CMD_ADD, pool_addr[4], pool_kind[4], 64'h1234_5678_9abc_def0, 1'b1);

		for (int p = 0; p < 8; p++) begin
			set_span(p == 5 ? 5'($urandom_range(0, 31)) : span_plan[p]);
			pool_n = 1 << $urandom_range(2, 5);
			for (int j = 0; j < 110; j++) begin
				if ($urandom_range(0, 19) == 0)
					burst = !burst;
				if ($urandom_range(0, 59) == 0)
					drain();
				roll = $urandom_range(0, 99);
				op = (roll < 40) ? CMD_ADD : (roll < 75) ? CMD_FIND :
					(roll < 93) ? CMD_DEL : CMD_NONE;
				pi = $urandom_range(0, pool_n - 1);
				a = pool_addr[pi];
				k = pool_kind[pi];
				if ($urandom_range(0, 19) == 0) begin
					a = ADDR_BITS'({$urandom, $urandom});
					k = KIND_BITS'($urandom);
				end
				send(op, a, k, {$urandom, $urandom}, $urandom_range(0, 6) != 0);
			end
		end

		drain();
		repeat (30) @(posedge clk);
		if (fail_count == 0 && results_owed == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
